>>> rtl/ibol_pkg.sv
// Shared types, sizes and helpers for the interval booking block.
package ibol_pkg;

	localparam int ACC_DEPTH = 64;
	localparam int OVL_DEPTH = 64;

	localparam int ACC_AW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
	localparam int OVL_AW = (OVL_DEPTH > 1) ? $clog2(OVL_DEPTH) : 1;
	localparam int ACC_CW = $clog2(ACC_DEPTH + 1);
	localparam int OVL_CW = $clog2(OVL_DEPTH + 1);
	localparam int IDX_W  = (ACC_CW > OVL_CW) ? ACC_CW : OVL_CW;
	localparam int SUM_W  = IDX_W + 1;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_TRIPLE = 2'd1,
		STATUS_FULL   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_OVL,
		ST_SCAN_ACC,
		ST_CHECK,
		ST_CLIP,
		ST_APPEND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [31:0] lo;
		logic signed [31:0] hi;
	} span_t;

	// Half-open intervals [s,e) and [lo,hi) share at least one point.
	function automatic logic meets(input logic signed [31:0] s, input logic signed [31:0] e,
			input span_t p);
		return (s < p.hi) && (e > p.lo);
	endfunction

endpackage

>>> rtl/interval_booking_overlap_limit.sv
// Interval booking with an overlap limit of two: sequencer around two span memories.
// A triple booking answers after the overlap scan alone.
// One request at a time; the scans over the stored entries set the pace.
// A finished status waits in an output register while the next request is taken.
// Reset clears both fill counts and the handshake state; memory contents are not cleared.
module interval_booking_overlap_limit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic signed [31:0] interval_start,
	input  logic signed [31:0] interval_end,
	output logic               status_valid,
	input  logic               status_stall,
	output logic [1:0]         booking_status
);

	// Span memories: one read port and one write port each, read data registered.
	ibol_pkg::span_t acc_mem [ibol_pkg::ACC_DEPTH];
	ibol_pkg::span_t ovl_mem [ibol_pkg::OVL_DEPTH];

	ibol_pkg::state_t state_q, state_d;

	// Request being worked on.
	logic signed [31:0] s_q, e_q;

	// Fill counts: entries below the count are valid.
	logic [ibol_pkg::ACC_CW-1:0] acc_cnt_q;
	logic [ibol_pkg::OVL_CW-1:0] ovl_cnt_q;
	logic [ibol_pkg::ACC_CW-1:0] hits_q;

	// Scan control: idx_q is the next address to read, pend_s1 marks read data in flight.
	logic [ibol_pkg::IDX_W-1:0] idx_q;
	logic                       pend_s1;
	ibol_pkg::span_t            acc_rdata_s1, ovl_rdata_s1;

	ibol_pkg::status_t result_q, result_d;
	logic              set_result;
	ibol_pkg::status_t status_q;
	logic              status_valid_q;

	logic issue, leave, acc_rd, ovl_rd, ovl_wr, acc_wr, load_out, accept;
	logic acc_hit, ovl_hit, full;
	logic [ibol_pkg::IDX_W-1:0] scan_cnt;
	ibol_pkg::span_t clip;

	assign accept   = req_valid && !req_stall;
	assign req_stall = (state_q != ibol_pkg::ST_IDLE);

	assign acc_hit = ibol_pkg::meets(s_q, e_q, acc_rdata_s1);
	assign ovl_hit = ibol_pkg::meets(s_q, e_q, ovl_rdata_s1);

	// Clipped overlap of the request with the accepted entry just read.
	assign clip.lo = (s_q > acc_rdata_s1.lo) ? s_q : acc_rdata_s1.lo;
	assign clip.hi = (e_q < acc_rdata_s1.hi) ? e_q : acc_rdata_s1.hi;

	// Full when the accepted table has no room or the clipped overlaps would not fit.
	assign full = (acc_cnt_q >= ibol_pkg::ACC_CW'(ibol_pkg::ACC_DEPTH)) ||
		((ibol_pkg::SUM_W'(hits_q) + ibol_pkg::SUM_W'(ovl_cnt_q)) >
		ibol_pkg::SUM_W'(ibol_pkg::OVL_DEPTH));

	assign scan_cnt = (state_q == ibol_pkg::ST_SCAN_OVL) ?
		ibol_pkg::IDX_W'(ovl_cnt_q) : ibol_pkg::IDX_W'(acc_cnt_q);

	assign ovl_wr = (state_q == ibol_pkg::ST_CLIP) && pend_s1 && acc_hit &&
		(ovl_cnt_q < ibol_pkg::OVL_CW'(ibol_pkg::OVL_DEPTH));
	assign acc_wr = (state_q == ibol_pkg::ST_APPEND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ibol_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory read enables and result selection.
	always_comb begin
		state_d    = state_q;
		issue      = 1'b0;
		acc_rd     = 1'b0;
		ovl_rd     = 1'b0;
		leave      = 1'b0;
		set_result = 1'b0;
		result_d   = ibol_pkg::STATUS_OK;
		load_out   = 1'b0;
		unique case (state_q)
			ibol_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = ibol_pkg::ST_SCAN_OVL;
					leave   = 1'b1;
				end
			end
			ibol_pkg::ST_SCAN_OVL: begin
				issue  = (idx_q < scan_cnt);
				ovl_rd = issue;
				if (pend_s1 && ovl_hit) begin
					state_d    = ibol_pkg::ST_DONE;
					leave      = 1'b1;
					set_result = 1'b1;
					result_d   = ibol_pkg::STATUS_TRIPLE;
				end else if (!issue && !pend_s1) begin
					state_d = ibol_pkg::ST_SCAN_ACC;
					leave   = 1'b1;
				end
			end
			ibol_pkg::ST_SCAN_ACC: begin
				issue  = (idx_q < scan_cnt);
				acc_rd = issue;
				if (!issue && !pend_s1) begin
					state_d = ibol_pkg::ST_CHECK;
					leave   = 1'b1;
				end
			end
			ibol_pkg::ST_CHECK: begin
				leave = 1'b1;
				if (full) begin
					state_d    = ibol_pkg::ST_DONE;
					set_result = 1'b1;
					result_d   = ibol_pkg::STATUS_FULL;
				end else begin
					state_d = ibol_pkg::ST_CLIP;
				end
			end
			ibol_pkg::ST_CLIP: begin
				issue  = (idx_q < scan_cnt);
				acc_rd = issue;
				if (!issue && !pend_s1) begin
					state_d = ibol_pkg::ST_APPEND;
					leave   = 1'b1;
				end
			end
			ibol_pkg::ST_APPEND: begin
				state_d    = ibol_pkg::ST_DONE;
				leave      = 1'b1;
				set_result = 1'b1;
				result_d   = ibol_pkg::STATUS_OK;
			end
			ibol_pkg::ST_DONE: begin
				// Hand over once the output register is free or being emptied.
				if (!status_valid_q || !status_stall) begin
					state_d  = ibol_pkg::ST_IDLE;
					load_out = 1'b1;
				end
			end
			default: begin
				state_d = ibol_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q          <= '0;
			pend_s1        <= 1'b0;
			acc_cnt_q      <= '0;
			ovl_cnt_q      <= '0;
			hits_q         <= '0;
			status_valid_q <= 1'b0;
		end else begin
			// Restart the scan on every state change but the return to idle; drop any read in flight.
			if (leave) begin
				idx_q   <= '0;
				pend_s1 <= 1'b0;
			end else begin
				idx_q   <= idx_q + ibol_pkg::IDX_W'(issue);
				pend_s1 <= issue;
			end
			if (accept) begin
				hits_q <= '0;
			end else if (state_q == ibol_pkg::ST_SCAN_ACC && pend_s1 && acc_hit) begin
				hits_q <= hits_q + ibol_pkg::ACC_CW'(1);
			end
			if (ovl_wr) begin
				ovl_cnt_q <= ovl_cnt_q + ibol_pkg::OVL_CW'(1);
			end
			if (acc_wr) begin
				acc_cnt_q <= acc_cnt_q + ibol_pkg::ACC_CW'(1);
			end
			if (load_out) begin
				status_valid_q <= 1'b1;
			end else if (!status_stall) begin
				status_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			s_q <= interval_start;
			e_q <= interval_end;
		end
		if (set_result) begin
			result_q <= result_d;
		end
		if (load_out) begin
			status_q <= result_q;
		end
	end

	// Accepted table: read during its scan and the clip pass, write on append.
	always_ff @(posedge clk) begin
		if (acc_rd) begin
			acc_rdata_s1 <= acc_mem[idx_q[ibol_pkg::ACC_AW-1:0]];
		end
		if (acc_wr) begin
			acc_mem[acc_cnt_q[ibol_pkg::ACC_AW-1:0]] <= '{lo: s_q, hi: e_q};
		end
	end

	// Overlap table: read during its scan, append clipped spans.
	always_ff @(posedge clk) begin
		if (ovl_rd) begin
			ovl_rdata_s1 <= ovl_mem[idx_q[ibol_pkg::OVL_AW-1:0]];
		end
		if (ovl_wr) begin
			ovl_mem[ovl_cnt_q[ibol_pkg::OVL_AW-1:0]] <= clip;
		end
	end

	assign status_valid   = status_valid_q;
	assign booking_status = status_q;

endmodule

>>> rtl/ibol_checker.sv
// Port-level checks for the interval booking block, bound to its top level.
module ibol_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               status_valid,
	input logic               status_stall,
	input logic [1:0]         booking_status
);

	// Hold a stalled status.
	a_status_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && status_stall |=> status_valid && $stable(booking_status))
		else $error("stalled status changed");

	// Only the three defined codes leave the block.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> (booking_status == ibol_pkg::STATUS_OK ||
		booking_status == ibol_pkg::STATUS_TRIPLE || booking_status == ibol_pkg::STATUS_FULL))
		else $error("undefined status code");

	// Stall new requests right after one is taken.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	// A new status appears only while a request is in work.
	a_status_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(status_valid) |-> $past(req_stall))
		else $error("status without a request");

endmodule

bind interval_booking_overlap_limit ibol_checker u_ibol_checker (.*);

>>> test/tb_interval_booking_overlap_limit.sv
// Self-checking testbench for the interval booking block with an overlap limit of two.
`timescale 1ns / 1ps

module tb_interval_booking_overlap_limit;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 8;
	localparam int RANDOM_REQUESTS = 1100;
	// Drain well past the worst request latency.
	localparam int DRAIN_CYCLES    = 250;
	// Watchdog limit, set well above the slowest correct run of 1115 requests.
	localparam int CYCLE_LIMIT     = 1_000_000;

	localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] T_MAX = 32'sh7fff_ffff;

	// One row of the directed part. When pinned is set, the status is typed in
	// and used as the expectation; otherwise the predictor supplies it.
	typedef struct packed {
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic               pinned;
		ibol_pkg::status_t  status;
	} directed_row_t;

	// One outstanding booking decision, oldest first.
	typedef struct {
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		ibol_pkg::status_t  status;
	} booking_verdict_t;

	localparam int DIRECTED_ROWS = 15;

	// Directed requests, issued in order right after reset.
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{32'sd0,     32'sd10,   1'b1, ibol_pkg::STATUS_OK},     // empty tables: always booked
		'{32'sd5,     32'sd15,   1'b1, ibol_pkg::STATUS_OK},     // single overlap, clipped
		'{32'sd8,     32'sd9,    1'b1, ibol_pkg::STATUS_TRIPLE}, // inside the double region
		'{T_MIN,      T_MAX,     1'b1, ibol_pkg::STATUS_TRIPLE}, // widest span hits everything
		'{T_MAX,      T_MIN,     1'b0, ibol_pkg::STATUS_OK},     // fully inverted extremes
		'{32'sd12,    32'sd12,   1'b0, ibol_pkg::STATUS_OK},     // empty span inside a booking
		'{T_MIN,      T_MIN,     1'b0, ibol_pkg::STATUS_OK},     // empty span at the bottom
		'{T_MAX,      T_MAX,     1'b0, ibol_pkg::STATUS_OK},     // empty span at the top
		'{-32'sd100,  -32'sd50,  1'b0, ibol_pkg::STATUS_OK},
		'{-32'sd80,   -32'sd60,  1'b0, ibol_pkg::STATUS_OK},
		'{-32'sd70,   -32'sd65,  1'b0, ibol_pkg::STATUS_OK},     // third layer: triple booking
		'{-32'sd60,   -32'sd50,  1'b0, ibol_pkg::STATUS_OK},     // abuts [-80,-60) at its end
		'{32'sd14,    32'sd16,   1'b0, ibol_pkg::STATUS_OK},
		'{-32'sd1,    32'sd0,    1'b0, ibol_pkg::STATUS_OK},     // abuts [0,10) from below
		'{32'sd10,    32'sd11,   1'b0, ibol_pkg::STATUS_OK}      // abuts [0,10) from above
	};

	logic               clk             = 1'b0;
	logic               arst_n          = 1'b0;
	logic               req_valid       = 1'b0;
	logic               req_stall;
	logic signed [31:0] interval_start  = '0;
	logic signed [31:0] interval_end    = '0;
	logic               status_valid;
	logic               status_stall    = 1'b0;
	logic [1:0]         booking_status;

	// Side band that travels with the request, kept in the bench: a typed-in status.
	logic               req_pinned        = 1'b0;
	ibol_pkg::status_t  req_pinned_status = ibol_pkg::STATUS_OK;

	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;
	int mismatch_count    = 0;
	int cycle_count       = 0;

	// Shadow copy of the booking state.
	logic signed [31:0] booked_lo [ibol_pkg::ACC_DEPTH];
	logic signed [31:0] booked_hi [ibol_pkg::ACC_DEPTH];
	int                 booked_count = 0;
	logic signed [31:0] double_lo [ibol_pkg::OVL_DEPTH];
	logic signed [31:0] double_hi [ibol_pkg::OVL_DEPTH];
	int                 double_count = 0;

	booking_verdict_t pending_verdicts [$];

	interval_booking_overlap_limit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.interval_start (interval_start),
		.interval_end   (interval_end),
		.status_valid   (status_valid),
		.status_stall   (status_stall),
		.booking_status (booking_status)
	);

	always #CLK_HALF clk = ~clk;

	// Half-open spans [s,e) and [lo,hi) share a point; signed compare, no guard
	// against empty or inverted spans.
	function automatic logic spans_touch(input logic signed [31:0] s,
			input logic signed [31:0] e,
			input logic signed [31:0] lo, input logic signed [31:0] hi);
		return (s < hi) && (e > lo);
	endfunction

	// Decide one request and advance the shadow tables when it is booked.
	function automatic ibol_pkg::status_t book_interval(input logic signed [31:0] s,
			input logic signed [31:0] e);
		int hits;
		hits = 0;
		// Triple check wins over every full condition.
		for (int i = 0; i < double_count; i++)
			if (spans_touch(s, e, double_lo[i], double_hi[i]))
				return ibol_pkg::STATUS_TRIPLE;
		for (int i = 0; i < booked_count; i++)
			if (spans_touch(s, e, booked_lo[i], booked_hi[i]))
				hits++;
		// Reject without touching state if either table would overflow.
		if (booked_count >= ibol_pkg::ACC_DEPTH || hits > ibol_pkg::OVL_DEPTH - double_count)
			return ibol_pkg::STATUS_FULL;
		// Append each clipped overlap, then the request itself.
		for (int i = 0; i < booked_count; i++) begin
			if (spans_touch(s, e, booked_lo[i], booked_hi[i]) &&
					double_count < ibol_pkg::OVL_DEPTH) begin
				double_lo[double_count] = (s > booked_lo[i]) ? s : booked_lo[i];
				double_hi[double_count] = (e < booked_hi[i]) ? e : booked_hi[i];
				double_count++;
			end
		end
		booked_lo[booked_count] = s;
		booked_hi[booked_count] = e;
		booked_count++;
		return ibol_pkg::STATUS_OK;
	endfunction

	// Pick a random request. Most land in a narrow window so that overlaps pile
	// up and the triple and full paths get exercised; the rest is noise.
	task automatic pick_request(output logic signed [31:0] s, output logic signed [31:0] e);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			s = int'($urandom_range(0, 4000)) - 2000;
			e = s + int'($urandom_range(1, 40));
		end else if (pick < 65) begin
			s = $urandom;
			e = $urandom;
		end else if (pick < 75) begin
			// empty or inverted span inside the window
			s = int'($urandom_range(0, 4000)) - 2000;
			e = s - int'($urandom_range(0, 20));
		end else if (pick < 90) begin
			s = int'($urandom_range(0, 4000)) - 2000;
			e = s + int'($urandom_range(40, 600));
		end else begin
			// hug the ends of the signed range, wrap included
			s = $urandom_range(0, 1) ? T_MIN + int'($urandom_range(0, 40))
				: T_MAX - int'($urandom_range(0, 40));
			e = $urandom_range(0, 1) ? T_MIN + int'($urandom_range(0, 40))
				: T_MAX - int'($urandom_range(0, 40));
		end
	endtask

	// Present one request at the falling edge, hold it until taken, and return
	// at the next falling edge. Idle gaps come first.
	task automatic drive_request(input logic signed [31:0] s, input logic signed [31:0] e,
			input logic pinned, input ibol_pkg::status_t pinned_status);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid         <= 1'b1;
		interval_start    <= s;
		interval_end      <= e;
		req_pinned        <= pinned;
		req_pinned_status <= pinned_status;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	// Receiver back-pressure: redraw the stall at each falling edge.
	always @(negedge clk) begin
		status_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
	end

	// Check results against the oldest verdict, then record the request taken
	// at this edge. A status can never belong to the request taken at the same edge.
	always @(posedge clk) begin
		booking_verdict_t  exp_v;
		ibol_pkg::status_t predicted;
		if (status_valid && !status_stall) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected booking status: expected none, actual %0d",
					$time, booking_status);
				mismatch_count++;
			end else begin
				exp_v = pending_verdicts.pop_front();
				if (booking_status !== exp_v.status) begin
					$display("%0t: status mismatch for [%0d,%0d): expected %0d (%s), actual %0d",
						$time, exp_v.lo, exp_v.hi, exp_v.status, exp_v.status.name(),
						booking_status);
					mismatch_count++;
				end
			end
		end
		if (arst_n && req_valid && !req_stall) begin
			predicted = book_interval(interval_start, interval_end);
			exp_v.lo     = interval_start;
			exp_v.hi     = interval_end;
			exp_v.status = req_pinned ? req_pinned_status : predicted;
			pending_verdicts.push_back(exp_v);
		end
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic signed [31:0] s;
		logic signed [31:0] e;

		// Hold reset, then release it away from the rising edge.
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Phase one: sender mostly busy, receiver stalls often.
		sender_idle_pct   = 17;
		receiver_idle_pct = 57;

		for (int r = 0; r < DIRECTED_ROWS; r++)
			drive_request(directed_rows[r].lo, directed_rows[r].hi,
				directed_rows[r].pinned, directed_rows[r].status);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			// Swap the idling rates a third of the way in, drop them in the last third.
			if (n == RANDOM_REQUESTS / 3) begin
				sender_idle_pct   = 57;
				receiver_idle_pct = 17;
			end else if (n == 2 * RANDOM_REQUESTS / 3) begin
				sender_idle_pct   = 0;
				receiver_idle_pct = 0;
			end
			pick_request(s, e);
			drive_request(s, e, 1'b0, ibol_pkg::STATUS_OK);
		end
		req_valid <= 1'b0;

		// Drain, then watch a while longer for stray results.
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_verdicts.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> files.f
rtl/ibol_pkg.sv
rtl/interval_booking_overlap_limit.sv
rtl/ibol_checker.sv
test/tb_interval_booking_overlap_limit.sv
